// ----- rtl/tst_pkg.sv -----
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types, codes and helpers of the terminal selection tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int MaxColumns      = 1024;
  localparam int ScrollbackDepth = 32768;
  localparam int LowRowInt       = (ScrollbackDepth > 32768) ? -32768 : -ScrollbackDepth;
  localparam logic signed [16:0] LowRow  = 17'(LowRowInt);
  localparam logic signed [16:0] HighRow = 17'sd32767;

  localparam int EvqDepth  = 2;
  localparam int EvqPtrW   = 1;
  localparam int ResqDepth = 2;
  localparam int ResqPtrW  = 1;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] CfgColumns    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenRows = 2'd1;

  localparam logic [10:0] ColumnsReset    = 11'd80;
  localparam logic [10:0] ScreenRowsReset = 11'd24;

  typedef enum logic [2:0] {
    FuncStart  = 3'd0,
    FuncUpdate = 3'd1,
    FuncExtend = 3'd2,
    FuncScroll = 3'd3,
    FuncDraw   = 3'd4,
    FuncClear  = 3'd5,
    FuncQuery  = 3'd6,
    FuncIdle   = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ModeChar = 2'd0,
    ModeLine = 2'd1
  } mode_e;

  typedef enum logic [3:0] {
    OpStartChar,
    OpStartLine,
    OpStartOff,
    OpUpdate,
    OpExtend,
    OpScroll,
    OpDraw,
    OpClear,
    OpQuery,
    OpNop
  } op_e;

  typedef enum logic [1:0] {
    NotifyNone    = 2'd0,
    NotifyActive  = 2'd1,
    NotifyCleared = 2'd2
  } notify_e;

  typedef struct packed {
    logic signed [15:0] r;
    logic        [9:0]  c;
  } pt_t;

  typedef struct packed {
    op_e        op;
    pt_t        p;
    logic       up;
    logic [9:0] lines;
    logic [9:0] top;
    logic [9:0] bottom;
  } evt_t;

  typedef struct packed {
    logic               active;
    logic signed [15:0] start_row;
    logic        [9:0]  start_col;
    logic signed [15:0] end_row;
    logic        [9:0]  end_col;
    logic               in_selection;
    notify_e            notify;
  } res_t;

  function automatic logic pt_lt(input pt_t a, input pt_t b);
    return ($signed(a.r) < $signed(b.r)) ||
           (($signed(a.r) == $signed(b.r)) && (a.c < b.c));
  endfunction

  function automatic logic [9:0] line_end_col(input logic [10:0] cols);
    logic [12:0] c;
    c = {2'b00, cols};
    if (c < 13'd1) c = 13'd1;
    if (c > 13'(MaxColumns)) c = 13'(MaxColumns);
    c = c - 13'd1;
    if (c > 13'd1023) c = 13'd1023;
    return c[9:0];
  endfunction

  function automatic logic row_moves(input logic signed [15:0] r, input logic up,
                                     input logic [9:0] top, input logic [9:0] bottom);
    logic signed [15:0] t;
    logic signed [15:0] b;
    t = $signed({6'd0, top});
    b = $signed({6'd0, bottom});
    if (up) return r <= b;
    return (r < 16'sd0) || ((r >= t) && (r <= b));
  endfunction

  function automatic logic signed [15:0] row_shift(input logic signed [15:0] r, input logic up,
                                                   input logic [9:0] lines);
    logic signed [16:0] v;
    if (up) begin
      v = $signed({r[15], r}) - $signed({7'd0, lines});
      if (v < LowRow) v = LowRow;
    end else begin
      v = $signed({r[15], r}) + $signed({7'd0, lines});
      if (v > HighRow) v = HighRow;
    end
    return v[15:0];
  endfunction

endpackage

// ----- rtl/tst_front.sv -----
// ----------------------------------------------------------------------------
// tst_front
// Accepts event words, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module tst_front import tst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         func_i,
  input  logic signed [15:0] row_i,
  input  logic [9:0]         col_i,
  input  logic [1:0]         mode_i,
  input  logic               scroll_up_i,
  input  logic [9:0]         lines_i,
  input  logic [9:0]         top_i,
  input  logic [9:0]         bottom_i,
  output logic               evt_valid_o,
  output evt_t               evt_o,
  input  logic               evt_pop_i
);

  evt_t               mem_q [EvqDepth];
  logic [EvqPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [EvqPtrW:0]   cnt_q, cnt_d;
  evt_t               dec;
  logic               do_push, do_pop;

  always_comb begin
    dec.p.r    = row_i;
    dec.p.c    = col_i;
    dec.up     = scroll_up_i;
    dec.lines  = lines_i;
    dec.top    = top_i;
    dec.bottom = bottom_i;
    unique case (func_e'(func_i))
      FuncStart: begin
        if (mode_i == ModeChar) begin
          dec.op = OpStartChar;
        end else if (mode_i == ModeLine) begin
          dec.op = OpStartLine;
        end else begin
          dec.op = OpStartOff;
        end
      end
      FuncUpdate: dec.op = OpUpdate;
      FuncExtend: dec.op = OpExtend;
      FuncScroll: dec.op = (lines_i == 10'd0) ? OpNop : OpScroll;
      FuncDraw:   dec.op = OpDraw;
      FuncClear:  dec.op = OpClear;
      FuncQuery:  dec.op = OpQuery;
      FuncIdle:   dec.op = OpNop;
      default:    dec.op = OpNop;
    endcase
  end

  assign full        = (cnt_q == (EvqPtrW+1)'(EvqDepth));
  assign do_push     = push && !full;
  assign evt_valid_o = (cnt_q != '0);
  assign do_pop      = evt_pop_i && evt_valid_o;
  assign evt_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == EvqPtrW'(EvqDepth-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == EvqPtrW'(EvqDepth-1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= dec;
    end
  end

endmodule

// ----- rtl/tst_back.sv -----
// ----------------------------------------------------------------------------
// tst_back
// Applies queued operations to the selection state and queues result words.
// ----------------------------------------------------------------------------
module tst_back import tst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        evt_valid_i,
  input  evt_t        evt_i,
  output logic        evt_pop_o,
  input  logic [9:0]  line_end_i,
  input  logic [10:0] screen_rows_i,
  input  logic        pop,
  output logic        empty,
  output res_t        res_o
);

  logic act_q, act_d, lm_q, lm_d;
  pt_t  anc_q, anc_d, fst_q, fst_d, lst_q, lst_d;

  res_t                res_mem_q [ResqDepth];
  logic [ResqPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ResqPtrW:0]   cnt_q, cnt_d;
  logic                exec, do_pop;
  res_t                res;

  pt_t                p, f1, l1, a1, lo_pt, hi_pt;
  logic               take_first;
  logic signed [16:0] two_pr, sum_r;
  logic [10:0]        two_pc, sum_c;
  logic               mv_f, mv_l, mv_a, full_scr;
  logic signed [15:0] vis;
  notify_e            notify;
  logic               insel;

  assign exec      = evt_valid_i && (cnt_q != (ResqPtrW+1)'(ResqDepth));
  assign evt_pop_o = exec;
  assign p         = evt_i.p;

  always_comb begin
    two_pr = $signed({p.r, 1'b0});
    sum_r  = $signed({fst_q.r[15], fst_q.r}) + $signed({lst_q.r[15], lst_q.r});
    two_pc = {p.c, 1'b0};
    sum_c  = {1'b0, fst_q.c} + {1'b0, lst_q.c};
    if (!pt_lt(fst_q, p)) begin
      take_first = 1'b1;
    end else if (!pt_lt(p, lst_q)) begin
      take_first = 1'b0;
    end else begin
      take_first = (two_pr < sum_r) || ((two_pr == sum_r) && (two_pc <= sum_c));
    end
    if (take_first) begin
      f1 = p;
      l1 = lst_q;
      a1 = lst_q;
    end else begin
      f1 = fst_q;
      l1 = p;
      a1 = fst_q;
    end
    mv_f     = row_moves(fst_q.r, evt_i.up, evt_i.top, evt_i.bottom);
    mv_l     = row_moves(lst_q.r, evt_i.up, evt_i.top, evt_i.bottom);
    mv_a     = row_moves(anc_q.r, evt_i.up, evt_i.top, evt_i.bottom);
    full_scr = (evt_i.top == 10'd0) &&
               ({2'b00, evt_i.bottom} == ({1'b0, screen_rows_i} - 12'd1));
    vis      = fst_q.r[15] ? 16'sd0 : fst_q.r;
    if (pt_lt(p, anc_q)) begin
      lo_pt = p;
      hi_pt = anc_q;
    end else begin
      lo_pt = anc_q;
      hi_pt = p;
    end
  end

  always_comb begin
    act_d  = act_q;
    lm_d   = lm_q;
    anc_d  = anc_q;
    fst_d  = fst_q;
    lst_d  = lst_q;
    notify = NotifyNone;
    insel  = 1'b0;
    unique case (evt_i.op)
      OpStartChar: begin
        anc_d  = p;
        lm_d   = 1'b0;
        fst_d  = p;
        lst_d  = p;
        act_d  = 1'b1;
        notify = NotifyActive;
      end
      OpStartLine: begin
        anc_d   = p;
        lm_d    = 1'b1;
        fst_d.r = p.r;
        fst_d.c = 10'd0;
        lst_d.r = p.r;
        lst_d.c = line_end_i;
        act_d   = 1'b1;
        notify  = NotifyActive;
      end
      OpStartOff: begin
        anc_d = p;
        lm_d  = 1'b0;
        act_d = 1'b0;
      end
      OpUpdate: begin
        if (act_q) begin
          if (!lm_q) begin
            fst_d = lo_pt;
            lst_d = hi_pt;
          end else begin
            fst_d.r = ($signed(p.r) < $signed(anc_q.r)) ? p.r : anc_q.r;
            fst_d.c = 10'd0;
            lst_d.r = ($signed(p.r) < $signed(anc_q.r)) ? anc_q.r : p.r;
            lst_d.c = line_end_i;
          end
        end
      end
      OpExtend: begin
        if (act_q) begin
          anc_d = a1;
          if (pt_lt(l1, f1)) begin
            fst_d = l1;
            lst_d = f1;
          end else begin
            fst_d = f1;
            lst_d = l1;
          end
        end
      end
      OpScroll: begin
        if (act_q) begin
          if ((mv_f || mv_l || mv_a) && !(mv_f && mv_l && mv_a) && !full_scr) begin
            act_d  = 1'b0;
            lm_d   = 1'b0;
            notify = NotifyCleared;
          end else begin
            if (mv_f) fst_d.r = row_shift(fst_q.r, evt_i.up, evt_i.lines);
            if (mv_l) lst_d.r = row_shift(lst_q.r, evt_i.up, evt_i.lines);
            if (mv_a) anc_d.r = row_shift(anc_q.r, evt_i.up, evt_i.lines);
          end
        end
      end
      OpDraw: begin
        if (act_q && !lst_q.r[15] && ($signed(p.r) >= vis) &&
            ($signed(p.r) <= $signed(lst_q.r))) begin
          act_d  = 1'b0;
          lm_d   = 1'b0;
          notify = NotifyCleared;
        end
      end
      OpClear: begin
        if (act_q) begin
          act_d  = 1'b0;
          lm_d   = 1'b0;
          notify = NotifyCleared;
        end
      end
      OpQuery: begin
        insel = act_q && !pt_lt(p, fst_q) && !pt_lt(lst_q, p);
      end
      OpNop: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.active       = act_d;
    res.start_row    = act_d ? fst_d.r : 16'sd0;
    res.start_col    = act_d ? fst_d.c : 10'd0;
    res.end_row      = act_d ? lst_d.r : 16'sd0;
    res.end_col      = act_d ? lst_d.c : 10'd0;
    res.in_selection = insel;
    res.notify       = notify;
  end

  assign empty  = (cnt_q == '0);
  assign do_pop = pop && !empty;
  assign res_o  = res_mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (exec) begin
      wr_d = (wr_q == ResqPtrW'(ResqDepth-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == ResqPtrW'(ResqDepth-1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({exec, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      lm_q  <= 1'b0;
      anc_q <= '0;
      fst_q <= '0;
      lst_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (exec) begin
        act_q <= act_d;
        lm_q  <= lm_d;
        anc_q <= anc_d;
        fst_q <= fst_d;
        lst_q <= lst_d;
      end
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_mem_q[wr_q] <= res;
    end
  end

endmodule

// ----- rtl/terminal_selection_tracker.sv -----
// ----------------------------------------------------------------------------
// terminal_selection_tracker
// Tracks one terminal text selection through start, drag, extend, scroll,
// redraw, clear and cell query events; one result word per event word.
//
//   channel   handshake            payload
//   events    push / full          func, row, col, mode, scroll_up, lines,
//                                  top, bottom
//   results   pop / empty          active, start/end row and col,
//                                  in_selection, notify
//   config    cfg_valid / ready    cfg_index, cfg_data (0 columns,
//                                  1 screen_rows)
//
// One event per cycle sustained while the result queue has room; an event
// passes through the event queue, then the state update into the result queue.
// The selection state updates once per event, which sets the rate.
// Reset clears the queues and the selection; columns resets to 80 and
// screen_rows to 24. A full result queue stalls the state update, and the
// event queue then fills and raises full.
// ----------------------------------------------------------------------------
module terminal_selection_tracker import tst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          func_i,
  input  logic signed [15:0]  row_i,
  input  logic [9:0]          col_i,
  input  logic [1:0]          mode_i,
  input  logic                scroll_up_i,
  input  logic [9:0]          lines_i,
  input  logic [9:0]          top_i,
  input  logic [9:0]          bottom_i,
  input  logic                pop,
  output logic                empty,
  output logic                active_o,
  output logic signed [15:0]  start_row_o,
  output logic [9:0]          start_col_o,
  output logic signed [15:0]  end_row_o,
  output logic [9:0]          end_col_o,
  output logic                in_selection_o,
  output logic [1:0]          notify_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        [10:0] columns_q, screen_rows_q;
  logic        [9:0]  line_end;
  logic               evt_valid, evt_pop;
  evt_t               evt;
  res_t               res;

  assign cfg_ready_o = 1'b1;
  assign line_end    = line_end_col(columns_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q     <= ColumnsReset;
      screen_rows_q <= ScreenRowsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgColumns) columns_q <= cfg_data_i;
      if (cfg_index_i == CfgScreenRows) screen_rows_q <= cfg_data_i;
    end
  end

  tst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .mode_i      (mode_i),
    .scroll_up_i (scroll_up_i),
    .lines_i     (lines_i),
    .top_i       (top_i),
    .bottom_i    (bottom_i),
    .evt_valid_o (evt_valid),
    .evt_o       (evt),
    .evt_pop_i   (evt_pop)
  );

  tst_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_valid_i   (evt_valid),
    .evt_i         (evt),
    .evt_pop_o     (evt_pop),
    .line_end_i    (line_end),
    .screen_rows_i (screen_rows_q),
    .pop           (pop),
    .empty         (empty),
    .res_o         (res)
  );

  assign active_o       = res.active;
  assign start_row_o    = res.start_row;
  assign start_col_o    = res.start_col;
  assign end_row_o      = res.end_row;
  assign end_col_o      = res.end_col;
  assign in_selection_o = res.in_selection;
  assign notify_o       = res.notify;

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !active_o) |-> (start_row_o == 16'sd0 && start_col_o == 10'd0 &&
                               end_row_o == 16'sd0 && end_col_o == 10'd0))
    else $error("inactive result carries a position");

  a_notify_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && notify_o == NotifyActive) |-> active_o)
    else $error("activation notice on an inactive selection");

  a_notify_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && notify_o == NotifyCleared) |-> !active_o)
    else $error("clear notice on an active selection");

  a_insel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && in_selection_o) |-> (active_o && notify_o == NotifyNone))
    else $error("cell hit without an active selection");

endmodule
